// ----- hw/rtl/nearest_square_root_approx_unit_defines.svh -----
// Assertion macros for the nearest square root approximation unit.
// Included by the top level; each macro expects clk_i and rst_ni in scope.
`ifndef NEAREST_SQUARE_ROOT_APPROX_UNIT_DEFINES_SVH
`define NEAREST_SQUARE_ROOT_APPROX_UNIT_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define NSRA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define NSRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/nsra_pkg.sv -----
// Package for the nearest square root approximation unit.
// Holds field widths and the search range tables; no dependencies.
`timescale 1ns / 1ps
package nsra_pkg;

  localparam int unsigned NumW     = 31;
  localparam int unsigned RootW    = 17;
  localparam int unsigned SqW      = 34;
  localparam int unsigned KW       = 3;
  localparam int unsigned OutRootW = 16;
  localparam int unsigned OutSqW   = 32;
  localparam int unsigned EstW     = 32;

  localparam logic [NumW-1:0] Ten2 = NumW'(100);
  localparam logic [NumW-1:0] Ten4 = NumW'(10000);
  localparam logic [NumW-1:0] Ten6 = NumW'(1000000);
  localparam logic [NumW-1:0] Ten8 = NumW'(100000000);

  function automatic logic [RootW-1:0] range_lo(input logic [KW-1:0] k);
    logic [RootW-1:0] v;
    case (k)
      3'd2:    v = RootW'(10);
      3'd3:    v = RootW'(100);
      3'd4:    v = RootW'(1000);
      3'd5:    v = RootW'(10000);
      default: v = RootW'(1);
    endcase
    return v;
  endfunction

  function automatic logic [RootW-1:0] range_hi(input logic [KW-1:0] k);
    logic [RootW-1:0] v;
    case (k)
      3'd2:    v = RootW'(99);
      3'd3:    v = RootW'(999);
      3'd4:    v = RootW'(9999);
      3'd5:    v = RootW'(99999);
      default: v = RootW'(9);
    endcase
    return v;
  endfunction

  function automatic logic [SqW-1:0] range_lo_sq(input logic [KW-1:0] k);
    logic [SqW-1:0] v;
    case (k)
      3'd2:    v = SqW'(100);
      3'd3:    v = SqW'(10000);
      3'd4:    v = SqW'(1000000);
      3'd5:    v = SqW'(100000000);
      default: v = SqW'(1);
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/nearest_square_root_approx_unit.sv -----
// Top level of the nearest square root approximation unit.
// Depends on nsra_pkg, nsra_sqr, nsra_div and the assertion macro header.
//
//   Channel  Signals                                         Direction
//   request  in_valid_i, in_stall_o, number_i                in
//   result   out_valid_o, out_stall_i, nearest_root_o,       out
//            nearest_square_o, approx_root_o
//
// The time of each binary-search probe is set by the bit-serial squarer.
// A request makes up to 17 probes, then 34 + FRAC_BITS divider steps.
// One request is worked on at a time; the next is taken once the result is
// handed to the output register, which may still be waiting on out_stall_i.
// Reset clears the control state only and needs no clearing pass.
`timescale 1ns / 1ps
`include "nearest_square_root_approx_unit_defines.svh"
module nearest_square_root_approx_unit import nsra_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [NumW-1:0]     number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OutRootW-1:0] nearest_root_o,
  output logic [OutSqW-1:0]   nearest_square_o,
  output logic [EstW-1:0]     approx_root_o
);

  localparam int unsigned DvdW = SqW + FRAC_BITS;
  localparam int unsigned DvsW = RootW + 1;
  localparam int unsigned EW   = DvdW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DIVS = 3'd4;
  localparam logic [2:0] S_DIVW = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]          state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic [NumW-1:0]     n_q, n_d;
  logic [RootW-1:0]    lo_q, lo_d;
  logic [RootW-1:0]    hi_q, hi_d;
  logic [RootW-1:0]    mid_q, mid_d;
  logic [RootW-1:0]    best_q, best_d;
  logic [SqW-1:0]      best_sq_q, best_sq_d;
  logic [SqW-1:0]      best_gap_q, best_gap_d;
  logic [OutRootW-1:0] out_root_q, out_root_d;
  logic [OutSqW-1:0]   out_sq_q, out_sq_d;
  logic [EstW-1:0]     out_est_q, out_est_d;

  logic                in_acc;
  logic                out_free;
  logic [KW-1:0]       k;
  logic [SqW-1:0]      lo_sq;
  logic [SqW-1:0]      num_x;
  logic [RootW:0]      mid_sum;
  logic                sqr_start;
  logic                sqr_done;
  logic [SqW-1:0]      sqr_prod;
  logic [SqW-1:0]      n_x;
  logic [SqW-1:0]      gap;
  logic                div_start;
  logic                div_done;
  logic [DvdW-1:0]     div_quo;
  logic [EW-1:0]       base;
  logic [EW-1:0]       corr;
  logic [EW-1:0]       est;

  nsra_sqr u_sqr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqr_start),
    .operand_i (mid_d),
    .done_o    (sqr_done),
    .square_o  (sqr_prod)
  );

  nsra_div #(
    .DvdW (DvdW),
    .DvsW (DvsW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DvdW'(best_gap_q) << FRAC_BITS),
    .divisor_i  ({best_q, 1'b0}),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign k = KW'(1) + KW'(number_i >= Ten2) + KW'(number_i >= Ten4) +
             KW'(number_i >= Ten6) + KW'(number_i >= Ten8);
  assign lo_sq = range_lo_sq(k);
  assign num_x = SqW'(number_i);

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign n_x     = SqW'(n_q);
  assign gap     = (sqr_prod > n_x) ? (sqr_prod - n_x) : (n_x - sqr_prod);

  assign sqr_start = (state_q == S_CHK) && (lo_q <= hi_q);
  assign div_start = (state_q == S_DIVS);

  assign base = EW'(best_q) << FRAC_BITS;
  assign corr = EW'(div_quo);

  always_comb begin
    if (best_sq_q > n_x) begin
      est = (corr > base) ? '0 : (base - corr);
    end else begin
      est = base + corr;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    best_d      = best_q;
    best_sq_d   = best_sq_q;
    best_gap_d  = best_gap_q;
    out_root_d  = out_root_q;
    out_sq_d    = out_sq_q;
    out_est_d   = out_est_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          n_d        = number_i;
          lo_d       = range_lo(k);
          hi_d       = range_hi(k);
          best_d     = range_lo(k);
          best_sq_d  = lo_sq;
          best_gap_d = (lo_sq > num_x) ? (lo_sq - num_x) : (num_x - lo_sq);
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (lo_q <= hi_q) begin
          mid_d   = mid_sum[RootW:1];
          state_d = S_SQR;
        end else begin
          state_d = S_DIVS;
        end
      end
      S_SQR: begin
        if (sqr_done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (gap < best_gap_q) begin
          best_d     = mid_q;
          best_sq_d  = sqr_prod;
          best_gap_d = gap;
        end
        if (sqr_prod == n_x) begin
          best_d     = mid_q;
          best_sq_d  = sqr_prod;
          best_gap_d = '0;
          state_d    = S_DIVS;
        end else begin
          if (sqr_prod > n_x) begin
            hi_d = mid_q - RootW'(1);
          end else begin
            lo_d = mid_q + RootW'(1);
          end
          state_d = S_CHK;
        end
      end
      S_DIVS: begin
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_root_d  = best_q[OutRootW-1:0];
          out_sq_d    = best_sq_q[OutSqW-1:0];
          out_est_d   = (|est[EW-1:EstW]) ? '1 : est[EstW-1:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    best_q     <= best_d;
    best_sq_q  <= best_sq_d;
    best_gap_q <= best_gap_d;
    out_root_q <= out_root_d;
    out_sq_q   <= out_sq_d;
    out_est_q  <= out_est_d;
  end

  assign out_valid_o      = out_valid_q;
  assign nearest_root_o   = out_root_q;
  assign nearest_square_o = out_sq_q;
  assign approx_root_o    = out_est_q;

  // The probe always lies inside the current search interval.
  `NSRA_ASSERT_IMPL(a_mid_in_range, state_q == S_SQR, (mid_q >= lo_q) && (mid_q <= hi_q), "probe outside search interval")
  // The squarer only finishes while a probe is waiting on it.
  `NSRA_ASSERT_IMPL(a_sqr_done_state, sqr_done, state_q == S_SQR, "unexpected squarer completion")
  // The divider only finishes while the correction is being waited on.
  `NSRA_ASSERT_IMPL(a_div_done_state, div_done, state_q == S_DIVW, "unexpected divider completion")
  // Starting a divide always leads to the wait state.
  `NSRA_ASSERT_NEXT(a_div_follow, div_start, state_q == S_DIVW, "divider start not followed by wait")

endmodule

// ----- hw/rtl/nsra_sqr.sv -----
// Bit-serial squarer: one multiplier bit per cycle, MSB first.
// Depends on nsra_pkg for the root and square widths.
`timescale 1ns / 1ps
module nsra_sqr import nsra_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RootW-1:0] operand_i,
  output logic             done_o,
  output logic [SqW-1:0]   square_o
);

  localparam int unsigned CntW = $clog2(RootW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [RootW-1:0] mcand_q, mcand_d;
  logic [RootW-1:0] mplier_q, mplier_d;
  logic [SqW-1:0]   acc_q, acc_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = CntW'(RootW);
      mcand_d  = operand_i;
      mplier_d = operand_i;
      acc_d    = '0;
    end else if (busy_q) begin
      acc_d    = {acc_q[SqW-2:0], 1'b0} +
                 (mplier_q[RootW-1] ? SqW'(mcand_q) : SqW'(0));
      mplier_d = {mplier_q[RootW-2:0], 1'b0};
      cnt_d    = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
  end

  assign done_o   = done_q;
  assign square_o = acc_q;

endmodule

// ----- hw/rtl/nsra_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on nsra_pkg only through the shared import convention.
`timescale 1ns / 1ps
module nsra_div import nsra_pkg::*; #(
  parameter int unsigned DvdW = 50,
  parameter int unsigned DvsW = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;
  logic            ge;

  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DvdW);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DvsW-1:0] : trial[DvsW-1:0];
      dvd_d = {dvd_q[DvdW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule
